FILE: src/rational_arith_unit_core_macros.svh
// Assertion macros for the rational arithmetic unit.
// Used by rational_arith_unit_core; empty when SYNTH is defined.
`ifndef RATIONAL_ARITH_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITH_UNIT_CORE_MACROS_SVH
`ifndef SYNTH
`define RAU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RAU_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT(label, clk, rst, prop, msg)
`define RAU_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: src/rau_pkg.sv
// Package for the rational arithmetic unit: command codes, word types, states.
// No dependencies.
`default_nettype none
package rau_pkg;
   localparam int OW = 16;
   localparam int NW = 33;
   localparam int DW = 31;
   localparam int MW = 2 * OW + 1;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic signed [OW-1:0] a_num;
      logic signed [OW-1:0] a_den;
      logic signed [OW-1:0] b_num;
      logic signed [OW-1:0] b_den;
   } req_word_type;

   typedef struct packed {
      logic signed [NW-1:0] res_num;
      logic [DW-1:0] res_den;
      logic zero_den_err;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_COMB, ST_GCD, ST_DIVN, ST_DIVD, ST_OUT
   } state_type;
endpackage
`default_nettype wire

FILE: src/rational_arith_unit_core.sv
// Rational arithmetic unit top level: cross products, gcd and reduction.
// Depends on rau_pkg and rational_arith_unit_core_macros.svh.
//
// Usage: a request word (cmd, two fractions) enters on req_valid when
// req_stall is low; one response word leaves on rsp_valid and is taken when
// rsp_stall is low. One word is in work at a time; req_stall stays high from
// acceptance until the response has been taken.
// Sequence: two multiply states, a combine state that also forms the denominator
// product, then a binary gcd on 32-bit magnitudes (one subtract-and-shift step
// per cycle), then two restoring divisions of 33 steps each through one shared
// subtractor, then the out state raises rsp_valid. The gcd loop and the single
// shared subtractor set how long a word takes. Zero denominators or division by
// a zero fraction return 0/0 with the error flag; the word goes straight from
// acceptance to the out state, which raises rsp_valid.
// Reset clears the sequencer and the output valid; no word is lost or
// invented. While the receiver stalls the response holds and no new request
// is taken.
`default_nettype none
`include "rational_arith_unit_core_macros.svh"
module rational_arith_unit_core
   import rau_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data
);
   localparam int OPERAND_WIDTH = OW;
   localparam int PW = 2 * OPERAND_WIDTH + 1;
   localparam int CW = $clog2(PW + 2);

   state_type state_ff, state_in;
   logic sn_an_ff, sn_ad_ff, sn_bn_ff, sn_bd_ff;
   logic sn_an_in, sn_ad_in, sn_bn_in, sn_bd_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [PW-1:0] p1_ff, p1_in, p2_ff, p2_in, dm_ff, dm_in;
   logic s1_ff, s1_in, s2_ff, s2_in, neg_ff, neg_in;
   logic [PW-1:0] x_ff, x_in, y_ff, y_in;
   logic [CW-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic [PW-1:0] nm_ff, nm_in, q_ff, q_in, r_ff, r_in, g_ff, g_in;
   logic [PW-1:0] nres_ff, nres_in;
   rsp_word_type out_ff, out_in;
   logic ov_ff, ov_in;

   logic [PW-1:0] prod, diff;
   logic borrow, bad;

   function automatic logic [OPERAND_WIDTH:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
      logic [OPERAND_WIDTH:0] e;
      e = {v[OPERAND_WIDTH-1], v};
      return e[OPERAND_WIDTH] ? (~e + (OPERAND_WIDTH + 1)'(1)) : e;
   endfunction

   // operand magnitudes fit OPERAND_WIDTH bits except the most negative value
   logic [OPERAND_WIDTH:0] m_an, m_ad, m_bn, m_bd;
   always_comb begin
      m_an = mag_of(req_data.a_num[OPERAND_WIDTH-1:0]);
      m_ad = mag_of(req_data.a_den[OPERAND_WIDTH-1:0]);
      m_bn = mag_of(req_data.b_num[OPERAND_WIDTH-1:0]);
      m_bd = mag_of(req_data.b_den[OPERAND_WIDTH-1:0]);
   end

   logic [OPERAND_WIDTH:0] xa_ff, xb_ff, xc_ff, xd_ff;
   logic [OPERAND_WIDTH:0] xa_in, xb_in, xc_in, xd_in;
   logic [OPERAND_WIDTH:0] opa, opb;
   logic [2*OPERAND_WIDTH+1:0] mp;

   // shared multiplier
   always_comb begin
      opa = xa_ff;
      opb = (cmd_ff == CMD_MUL) ? xc_ff : xd_ff;
      case (state_ff)
         ST_MUL1: begin
            opa = xa_ff;
            opb = (cmd_ff == CMD_MUL) ? xc_ff : xd_ff;
         end
         ST_MUL2: begin
            opa = (cmd_ff == CMD_DIV) ? xb_ff : xc_ff;
            opb = (cmd_ff == CMD_DIV) ? xc_ff : xb_ff;
         end
         ST_COMB: begin
            opa = xb_ff;
            opb = (cmd_ff == CMD_DIV) ? xc_ff : xd_ff;
         end
         default: begin
            opa = xa_ff;
            opb = xd_ff;
         end
      endcase
      mp = opa * opb;
      prod = mp[PW-1:0];
   end

   // shared subtractor
   logic [PW-1:0] sub_a, sub_b;
   always_comb begin
      case (state_ff)
         ST_GCD: begin
            sub_a = (x_ff >= y_ff) ? x_ff : y_ff;
            sub_b = (x_ff >= y_ff) ? y_ff : x_ff;
         end
         ST_DIVN, ST_DIVD: begin
            sub_a = {r_ff[PW-2:0], q_ff[PW-1]};
            sub_b = g_ff;
         end
         default: begin
            sub_a = p1_ff;
            sub_b = p2_ff;
         end
      endcase
      {borrow, diff} = {1'b0, sub_a} - {1'b0, sub_b};
   end

   always_comb begin
      bad = (m_ad == '0) || (m_bd == '0) || ((req_data.cmd == CMD_DIV) && (m_bn == '0));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = bad ? ST_OUT : ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_COMB;
         ST_COMB: state_in = ST_GCD;
         ST_GCD:  if (x_ff == '0 || y_ff == '0) state_in = ST_DIVN;
         ST_DIVN: if (cnt_ff == CW'(PW - 1)) state_in = ST_DIVD;
         ST_DIVD: if (cnt_ff == CW'(PW - 1)) state_in = ST_OUT;
         ST_OUT:  if (!ov_ff || !rsp_stall) state_in = ov_ff ? ST_IDLE : ST_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      sn_an_in = sn_an_ff; sn_ad_in = sn_ad_ff; sn_bn_in = sn_bn_ff; sn_bd_in = sn_bd_ff;
      xa_in = xa_ff; xb_in = xb_ff; xc_in = xc_ff; xd_in = xd_ff;
      cmd_in = cmd_ff; p1_in = p1_ff; p2_in = p2_ff; s1_in = s1_ff; s2_in = s2_ff;
      dm_in = dm_ff; neg_in = neg_ff; x_in = x_ff; y_in = y_ff; k_in = k_ff;
      cnt_in = cnt_ff; nm_in = nm_ff; q_in = q_ff; r_in = r_ff; g_in = g_ff;
      nres_in = nres_ff; out_in = out_ff; ov_in = ov_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd_in = req_data.cmd;
            xa_in = m_an; xb_in = m_ad; xc_in = m_bn; xd_in = m_bd;
            sn_an_in = req_data.a_num[OPERAND_WIDTH-1];
            sn_ad_in = req_data.a_den[OPERAND_WIDTH-1];
            sn_bn_in = req_data.b_num[OPERAND_WIDTH-1];
            sn_bd_in = req_data.b_den[OPERAND_WIDTH-1];
            if (bad) begin
               out_in.res_num = '0; out_in.res_den = '0; out_in.zero_den_err = 1'b1;
            end
         end
         ST_MUL1: begin
            p1_in = prod;
            s1_in = (prod != '0) && (cmd_ff == CMD_MUL ? (sn_an_ff ^ sn_bn_ff)
                                                      : (sn_an_ff ^ sn_bd_ff));
         end
         ST_MUL2: begin
            p2_in = prod;
            if (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB)
               s2_in = (prod != '0) && (sn_bn_ff ^ sn_ad_ff ^ (cmd_ff == CMD_SUB));
            else
               s2_in = (cmd_ff == CMD_MUL) ? (sn_ad_ff ^ sn_bd_ff) : (sn_ad_ff ^ sn_bn_ff);
         end
         ST_COMB: begin
            if (cmd_ff == CMD_MUL || cmd_ff == CMD_DIV) begin
               nm_in = p1_ff;
               neg_in = s1_ff ^ s2_ff;
            end else if (s1_ff == s2_ff) begin
               nm_in = p1_ff + p2_ff;
               neg_in = s1_ff ^ (sn_ad_ff ^ sn_bd_ff);
            end else if (!borrow) begin
               nm_in = diff;
               neg_in = s1_ff ^ (sn_ad_ff ^ sn_bd_ff);
            end else begin
               nm_in = p2_ff - p1_ff;
               neg_in = s2_ff ^ (sn_ad_ff ^ sn_bd_ff);
            end
            x_in = (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) ?
                   ((s1_ff == s2_ff) ? p1_ff + p2_ff : (!borrow ? diff : p2_ff - p1_ff))
                   : p1_ff;
            dm_in = prod;
            y_in = prod;
            k_in = '0;
         end
         ST_GCD: begin
            if (x_ff == '0 || y_ff == '0) begin
               g_in = (x_ff | y_ff) << k_ff;
               if (nm_ff == '0) g_in = dm_ff;
               q_in = nm_ff; r_in = '0; cnt_in = '0;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1; y_in = y_ff >> 1; k_in = k_ff + CW'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = diff >> 1;
            end else begin
               y_in = diff >> 1;
            end
         end
         ST_DIVN, ST_DIVD: begin
            if (!borrow) begin
               r_in = diff; q_in = {q_ff[PW-2:0], 1'b1};
            end else begin
               r_in = sub_a; q_in = {q_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(PW - 1)) begin
               cnt_in = '0;
               if (state_ff == ST_DIVN) begin
                  nres_in = (!borrow) ? {q_ff[PW-2:0], 1'b1} : {q_ff[PW-2:0], 1'b0};
                  q_in = dm_ff; r_in = '0;
               end else begin
                  out_in.res_num = NW'(neg_ff ? (~nres_ff + PW'(1)) : nres_ff);
                  if (nm_ff == '0) out_in.res_num = '0;
                  out_in.res_den = DW'((!borrow) ? {q_ff[PW-2:0], 1'b1}
                                                 : {q_ff[PW-2:0], 1'b0});
                  out_in.zero_den_err = 1'b0;
               end
            end
         end
         ST_OUT: begin
            if (!ov_ff) ov_in = 1'b1;
            else if (!rsp_stall) ov_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
      end
      sn_an_ff <= sn_an_in; sn_ad_ff <= sn_ad_in; sn_bn_ff <= sn_bn_in; sn_bd_ff <= sn_bd_in;
      xa_ff <= xa_in; xb_ff <= xb_in; xc_ff <= xc_in; xd_ff <= xd_in;
      cmd_ff <= cmd_in; p1_ff <= p1_in; p2_ff <= p2_in; s1_ff <= s1_in; s2_ff <= s2_in;
      dm_ff <= dm_in; neg_ff <= neg_in; x_ff <= x_in; y_ff <= y_in; k_ff <= k_in;
      cnt_ff <= cnt_in; nm_ff <= nm_in; q_ff <= q_in; r_ff <= r_in; g_ff <= g_in;
      nres_ff <= nres_in; out_ff <= out_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;

   `RAU_ASSERT(a_busy_no_rsp, clock, reset, (state_ff != ST_OUT) |-> !rsp_valid, "rsp outside out state")
   `RAU_ASSERT(a_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "rsp dropped while stalled")
   `RAU_ASSERT(a_stall, clock, reset, rsp_valid |-> req_stall, "request taken with rsp pending")
   `RAU_ASSERT(a_err, clock, reset, (rsp_valid && rsp_data.zero_den_err) |-> (rsp_data.res_den == '0), "err with nonzero den")
endmodule
`default_nettype wire

FILE: tb/sv/rational_arith_unit_core_tb.sv
// Self-checking bench for rational_arith_unit_core: directed table, then random
// fraction words, each response checked against a typed table value or an in-bench fraction predictor.
// Depends on rau_pkg and the core RTL.
`timescale 1ns / 1ps
module rational_arith_unit_core_tb
   import rau_pkg::*;
();

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   rsp_word_type fraction_queue[$];
   int fault_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   rational_arith_unit_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #60000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic rsp_word_type reduce_fraction(req_word_type w);
      rsp_word_type r;
      longint an, ad, bn, bd, n, d, g, nm, dm;
      an = w.a_num; ad = w.a_den; bn = w.b_num; bd = w.b_den;
      r = '0;
      if (ad == 0 || bd == 0 || (w.cmd == CMD_DIV && bn == 0)) begin
         r.zero_den_err = 1'b1;
         return r;
      end
      case (w.cmd)
         CMD_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
         CMD_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
         CMD_MUL: begin n = an * bn; d = ad * bd; end
         default: begin n = an * bd; d = ad * bn; end
      endcase
      if (n == 0) begin
         r.res_den = 31'd1;
         return r;
      end
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      nm = (n < 0) ? -n : n;
      g = longint'(gcd_of(nm, d));
      n = n / g;
      d = d / g;
      r.res_num = n[NW-1:0];
      r.res_den = d[DW-1:0];
      return r;
   endfunction

   task automatic report_fault(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fault_count++;
   endtask

   task automatic send_word(req_word_type w, bit typed, rsp_word_type want);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fraction_queue.push_back(typed ? want : reduce_fraction(w));
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99, 0) < recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fraction_queue.size() == 0) begin
            report_fault("unexpected word", 0, 0);
         end else begin
            rsp_word_type e;
            e = fraction_queue.pop_front();
            if (rsp_data.res_num !== e.res_num)
               report_fault("res_num", rsp_data.res_num, e.res_num);
            if (rsp_data.res_den !== e.res_den)
               report_fault("res_den", rsp_data.res_den, e.res_den);
            if (rsp_data.zero_den_err !== e.zero_den_err)
               report_fault("zero_den_err", rsp_data.zero_den_err, e.zero_den_err);
         end
      end
   end

   typedef struct {
      req_word_type w;
      bit typed;
      rsp_word_type want;
   } table_row_type;

   function automatic req_word_type make_word(logic [1:0] c, int an, int ad, int bn, int bd);
      req_word_type w;
      w.cmd = c;
      w.a_num = an[15:0]; w.a_den = ad[15:0]; w.b_num = bn[15:0]; w.b_den = bd[15:0];
      return w;
   endfunction

   function automatic rsp_word_type make_rsp(longint n, longint d, bit e);
      rsp_word_type r;
      r.res_num = n[NW-1:0];
      r.res_den = d[DW-1:0];
      r.zero_den_err = e;
      return r;
   endfunction

   function automatic int rand_operand();
      case ($urandom_range(5, 0))
         0: return $urandom_range(8, 0) - 4;
         1: return $urandom_range(1, 0) ? 32767 : -32768;
         2: return $urandom_range(200, 0) - 100;
         default: return int'($signed($urandom_range(65535, 0) - 32768));
      endcase
   endfunction

   task automatic run_random(int count);
      req_word_type w;
      int bd, ad;
      repeat (count) begin
         ad = rand_operand();
         bd = rand_operand();
         if ($urandom_range(19, 0) != 0) begin
            if (ad == 0) ad = 1;
            if (bd == 0) bd = -1;
         end
         w = make_word(2'($urandom_range(3, 0)), rand_operand(), ad, rand_operand(), bd);
         send_word(w, 1'b0, '0);
      end
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (fraction_queue.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   table_row_type stim_table[$];

   initial begin
      stim_table.push_back('{make_word(CMD_ADD, 1, 2, 1, 3), 1, make_rsp(5, 6, 0)});
      stim_table.push_back('{make_word(CMD_SUB, 1, 2, 1, 2), 1, make_rsp(0, 1, 0)});
      stim_table.push_back('{make_word(CMD_MUL, 0, 5, 7, 9), 1, make_rsp(0, 1, 0)});
      stim_table.push_back('{make_word(CMD_DIV, 3, 4, 0, 5), 1, make_rsp(0, 0, 1)});
      stim_table.push_back('{make_word(CMD_ADD, 1, 0, 1, 3), 1, make_rsp(0, 0, 1)});
      stim_table.push_back('{make_word(CMD_MUL, 1, 3, 1, 0), 1, make_rsp(0, 0, 1)});
      stim_table.push_back('{make_word(CMD_DIV, 0, 0, 0, 0), 1, make_rsp(0, 0, 1)});
      stim_table.push_back('{make_word(CMD_MUL, -32768, 1, -32768, 1), 1,
                             make_rsp(1073741824, 1, 0)});
      stim_table.push_back('{make_word(CMD_MUL, 1, -32768, 1, -32768), 1,
                             make_rsp(1, 1073741824, 0)});
      stim_table.push_back('{make_word(CMD_SUB, -32768, 1, 32767, -32768), 1, '0});
      stim_table.push_back('{make_word(CMD_ADD, -32768, 1, -32768, 1), 1,
                             make_rsp(-65536, 1, 0)});
      stim_table.push_back('{make_word(CMD_ADD, 32767, 32767, -32768, -32768), 1,
                             make_rsp(2, 1, 0)});
      stim_table.push_back('{make_word(CMD_DIV, 32767, -1, -32768, 32767), 0, '0});
      stim_table.push_back('{make_word(CMD_ADD, -32768, -32767, -32768, 32767), 0, '0});
      stim_table.push_back('{make_word(CMD_SUB, -3, 7, 5, -11), 0, '0});
      stim_table.push_back('{make_word(CMD_DIV, 6, -4, -9, 2), 0, '0});
      stim_table.push_back('{make_word(CMD_MUL, 32767, 32767, 32767, 32767), 1,
                             make_rsp(1, 1, 0)});
      stim_table[9].typed = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (stim_table[i])
         send_word(stim_table[i].w, stim_table[i].typed, stim_table[i].want);
      run_random(400);
      send_idle_pct = 66;
      run_random(380);
      send_idle_pct = 0;
      recv_stall_pct = 66;
      run_random(380);
      send_idle_pct = 12;
      recv_stall_pct = 12;
      run_random(380);
      req_valid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      repeat (200) @(posedge clock);
      if (fault_count == 0 && fraction_queue.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+src
src/rau_pkg.sv
src/rational_arith_unit_core.sv
tb/sv/rational_arith_unit_core_tb.sv
